@@ rtl/btlv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btlv_pkg
// Shared types and codes for the BER-TLV header parser and tag finder.
// ----------------------------------------------------------------------------
package btlv_pkg;

    localparam int NUM_MATCH_TAGS   = 4;
    localparam int MAX_LENGTH_BYTES = 4;
    localparam int OUT_DEPTH        = 4;

    localparam logic [2:0] CFG_MATCH_TAG_0     = 3'd0;
    localparam logic [2:0] CFG_MATCH_TAG_1     = 3'd1;
    localparam logic [2:0] CFG_MATCH_TAG_2     = 3'd2;
    localparam logic [2:0] CFG_MATCH_TAG_3     = 3'd3;
    localparam logic [2:0] CFG_MATCH_TAG_COUNT = 3'd4;
    localparam logic [2:0] CFG_REPORT_ALL      = 3'd5;

    localparam logic [1:0] ST_ELEMENT   = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_LEN_LONG  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [4:0] TAG_MULTI_MASK = 5'b11111;

    typedef struct packed {
        logic [15:0] element_tag;
        logic [31:0] element_offset;
        logic [31:0] value_offset;
        logic [31:0] value_length;
        logic        tag_matched;
        logic [1:0]  status;
        logic        last_of_run;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/ber_tlv_header_parser_tag_finder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ber_tlv_header_parser_tag_finder
// Walks top-level BER-TLV elements one byte a word and reports tag hits or, in report-all mode, every element.
// ----------------------------------------------------------------------------
// Input stream s_axis: one buffer byte per word, tlast on the buffer's last
// byte. Output stream m_axis: one word per reported element; tuser carries
// the status (element, truncated, length field too long, not found), tlast
// marks the final result caused by one input byte.
// One input byte is accepted per cycle while s_axis_tready is high. Its results
// are written into a four-entry output queue on the accepting edge and leave on
// m_axis in order. A byte yields at most two results, two only on a buffer's
// last byte; s_axis_tready is high while the queue has room for two. With a
// receiver that takes a word every cycle the block takes one byte per cycle,
// except that a run of bytes that each yield two words fills the queue faster
// than it drains and drops s_axis_tready. When the receiver stalls, the queue
// fills and s_axis_tready drops; nothing is lost.
// The user writes configuration (cfg_we, cfg_index, cfg_data) only while the
// block is idle; the block itself does not enforce this. Reset clears the parse
// state and the queue and loads the register defaults (match tags 0, one active match tag, find-first mode).
// ----------------------------------------------------------------------------
module ber_tlv_header_parser_tag_finder
    import btlv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tlast,   // end_of_buffer
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [15:0] element_tag, [47:16] element_offset, [79:48] value_offset,
    // [111:80] value_length, [112] tag_matched, [119:113] zero
    output logic [119:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser,   // [1:0] status
    output logic              m_axis_tlast    // last_of_run
);

    typedef enum logic [2:0] {
        PH_TAG1,
        PH_TAG2,
        PH_LEN1,
        PH_LENX,
        PH_VALUE
    } phase_t;

    logic [15:0] match_tag_reg [NUM_MATCH_TAGS];
    logic [2:0]  match_count_reg;
    logic        report_all_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [31:0] val_left_reg, val_left_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] elem_start_reg, elem_start_next;
    logic [31:0] val_start_reg, val_start_next;
    logic        done_reg, done_next;

    result_t     res0, res1;
    logic [1:0]  nres;
    logic        accept;
    logic        pop;

    result_t     queue_reg [OUT_DEPTH];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (count_reg <= 3'(OUT_DEPTH - 2));
    assign m_axis_tvalid = (count_reg != 3'd0);

    always_comb
    begin
        logic [7:0] b;
        logic       header_done;
        logic       complete;
        logic       hit;
        logic [6:0] n;
        result_t    r;
        b           = s_axis_tdata;
        header_done = 1'b0;
        complete    = 1'b0;
        hit         = 1'b0;
        n           = b[6:0];
        r           = '0;

        phase_next      = phase_reg;
        tag_next        = tag_reg;
        len_next        = len_reg;
        len_left_next   = len_left_reg;
        val_left_next   = val_left_reg;
        pos_next        = pos_reg;
        elem_start_next = elem_start_reg;
        val_start_next  = val_start_reg;
        done_next       = done_reg;
        res0            = '0;
        res1            = '0;
        nres            = 2'd0;

        if (accept)
        begin
            pos_next = pos_reg + 32'd1;
            if (!done_reg)
            begin
                case (phase_reg)
                    PH_TAG1:
                    begin
                        elem_start_next = pos_reg;
                        tag_next        = {8'd0, b};
                        len_next        = '0;
                        val_start_next  = '0;
                        len_left_next   = '0;
                        val_left_next   = '0;
                        phase_next      = (b[4:0] == TAG_MULTI_MASK) ? PH_TAG2 : PH_LEN1;
                    end
                    PH_TAG2:
                    begin
                        tag_next   = {tag_reg[7:0], b};
                        phase_next = PH_LEN1;
                    end
                    PH_LEN1:
                    begin
                        if (b[7])
                        begin
                            if (n > 7'(MAX_LENGTH_BYTES))
                            begin
                                r.element_tag    = tag_reg;
                                r.element_offset = elem_start_reg;
                                r.value_length   = {25'd0, n};
                                r.status         = ST_LEN_LONG;
                                res0             = r;
                                nres             = 2'd1;
                                done_next        = 1'b1;
                                phase_next       = PH_TAG1;
                            end
                            else if (n == 7'd0)
                            begin
                                len_next    = '0;
                                header_done = 1'b1;
                            end
                            else
                            begin
                                len_next      = '0;
                                len_left_next = n[2:0];
                                phase_next    = PH_LENX;
                            end
                        end
                        else
                        begin
                            len_next    = {24'd0, b};
                            header_done = 1'b1;
                        end
                    end
                    PH_LENX:
                    begin
                        len_next = {len_reg[23:0], b};
                        if (len_left_reg != 3'd0)
                            len_left_next = len_left_reg - 3'd1;
                        if (len_left_next == 3'd0)
                            header_done = 1'b1;
                    end
                    default:
                    begin
                        if (val_left_reg != 32'd0)
                            val_left_next = val_left_reg - 32'd1;
                        if (val_left_next == 32'd0)
                            complete = 1'b1;
                    end
                endcase

                if (header_done)
                begin
                    val_start_next = pos_reg + 32'd1;
                    if (len_next == 32'd0)
                        complete = 1'b1;
                    else
                    begin
                        val_left_next = len_next;
                        phase_next    = PH_VALUE;
                    end
                end

                if (complete)
                begin
                    for (int i = 0; i < NUM_MATCH_TAGS; i++)
                        if (match_count_reg > 3'(i) && match_tag_reg[i] == tag_next)
                            hit = 1'b1;
                    phase_next       = PH_TAG1;
                    r                = '0;
                    r.element_tag    = tag_next;
                    r.element_offset = elem_start_next;
                    r.value_offset   = val_start_next;
                    r.value_length   = len_next;
                    r.tag_matched    = hit;
                    r.status         = ST_ELEMENT;
                    if (report_all_reg)
                    begin
                        res0 = r;
                        nres = 2'd1;
                    end
                    else if (hit)
                    begin
                        res0      = r;
                        nres      = 2'd1;
                        done_next = 1'b1;
                    end
                end
            end

            if (s_axis_tlast)
            begin
                if (!done_next)
                begin
                    if (phase_next != PH_TAG1)
                    begin
                        r                = '0;
                        r.element_tag    = tag_next;
                        r.element_offset = elem_start_next;
                        r.value_offset   = val_start_next;
                        r.value_length   = len_next;
                        r.status         = ST_TRUNCATED;
                        res0             = r;
                        nres             = 2'd1;
                    end
                    if (!report_all_reg)
                    begin
                        r        = '0;
                        r.status = ST_NOT_FOUND;
                        if (nres == 2'd0)
                        begin
                            res0 = r;
                            nres = 2'd1;
                        end
                        else
                        begin
                            res1 = r;
                            nres = 2'd2;
                        end
                    end
                end
                phase_next      = PH_TAG1;
                tag_next        = '0;
                len_next        = '0;
                len_left_next   = '0;
                val_left_next   = '0;
                pos_next        = '0;
                elem_start_next = '0;
                val_start_next  = '0;
                done_next       = 1'b0;
            end

            if (nres == 2'd1)
                res0.last_of_run = 1'b1;
            if (nres == 2'd2)
                res1.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MATCH_TAGS; i++)
                match_tag_reg[i] <= '0;
            match_count_reg <= 3'd1;
            report_all_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MATCH_TAG_0:     match_tag_reg[0] <= cfg_data;
                CFG_MATCH_TAG_1:     match_tag_reg[1] <= cfg_data;
                CFG_MATCH_TAG_2:     match_tag_reg[2] <= cfg_data;
                CFG_MATCH_TAG_3:     match_tag_reg[3] <= cfg_data;
                CFG_MATCH_TAG_COUNT: match_count_reg  <= cfg_data[2:0];
                CFG_REPORT_ALL:      report_all_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TAG1;
            tag_reg        <= '0;
            len_reg        <= '0;
            len_left_reg   <= '0;
            val_left_reg   <= '0;
            pos_reg        <= '0;
            elem_start_reg <= '0;
            val_start_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tag_reg        <= tag_next;
            len_reg        <= len_next;
            len_left_reg   <= len_left_next;
            val_left_reg   <= val_left_next;
            pos_reg        <= pos_next;
            elem_start_reg <= elem_start_next;
            val_start_reg  <= val_start_next;
            done_reg       <= done_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (nres != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (nres == 2'd2)
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + nres;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {1'b0, nres} - {2'd0, pop};
        end
    end

    always_comb
    begin
        result_t q;
        q             = queue_reg[rd_ptr_reg];
        m_axis_tdata  = {7'd0, q.tag_matched, q.value_length, q.value_offset,
                         q.element_offset, q.element_tag};
        m_axis_tuser  = q.status;
        m_axis_tlast  = q.last_of_run;
    end

endmodule

`default_nettype wire

@@ tb/tlv_report_predictor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlv_report_predictor
// Watches the byte stream, the register port and the result stream of the
// BER-TLV tag finder. Each accepted byte runs through a local element walker
// that predicts the result words; each accepted result word is compared in
// order against the oldest prediction.
// ----------------------------------------------------------------------------
module tlv_report_predictor
    import btlv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [119:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           mismatches,
    output int           words_due
);

    typedef enum logic [2:0] {
        WANT_TAG,
        WANT_TAG_LOW,
        WANT_LEN,
        WANT_LEN_BYTES,
        IN_VALUE
    } walk_e;

    logic [15:0] tag_list [NUM_MATCH_TAGS];
    logic [2:0]  tags_active;
    logic        every_element;

    walk_e       walk;
    logic [15:0] tag_acc;
    logic [31:0] len_acc;
    logic [2:0]  len_bytes_left;
    logic [31:0] value_left;
    logic [31:0] byte_pos;
    logic [31:0] elem_start;
    logic [31:0] value_start;
    logic        search_done;

    result_t     due_q[$];
    result_t     want;
    int          err_cnt = 0;

    task automatic clear_walk();
        walk           = WANT_TAG;
        tag_acc        = '0;
        len_acc        = '0;
        len_bytes_left = '0;
        value_left     = '0;
        byte_pos       = '0;
        elem_start     = '0;
        value_start    = '0;
        search_done    = 1'b0;
    endtask

    function automatic logic tag_hit(input logic [15:0] t);
        int   lim;
        logic found;
        lim   = (tags_active > NUM_MATCH_TAGS) ? NUM_MATCH_TAGS : int'(tags_active);
        found = 1'b0;
        for (int i = 0; i < lim; i++)
            if (tag_list[i] == t)
                found = 1'b1;
        return found;
    endfunction

    function automatic result_t make_word(input logic [15:0] t, input logic [31:0] eoff,
                                          input logic [31:0] voff, input logic [31:0] vlen,
                                          input logic hit, input logic [1:0] st);
        result_t r;
        r.element_tag    = t;
        r.element_offset = eoff;
        r.value_offset   = voff;
        r.value_length   = vlen;
        r.tag_matched    = hit;
        r.status         = st;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    // One buffer byte through the walker; pushes zero, one or two words.
    task automatic walk_byte(input logic [7:0] b, input logic eob);
        logic [31:0] here;
        logic        hdr_done;
        logic        complete;
        logic        hit;
        int          first_new;
        first_new = due_q.size();
        hdr_done  = 1'b0;
        complete  = 1'b0;
        here      = byte_pos;
        byte_pos  = here + 32'd1;

        if (!search_done)
        begin
            case (walk)
                WANT_TAG:
                begin
                    elem_start     = here;
                    tag_acc        = {8'h00, b};
                    len_acc        = '0;
                    value_start    = '0;
                    len_bytes_left = '0;
                    value_left     = '0;
                    walk = (b[4:0] == TAG_MULTI_MASK) ? WANT_TAG_LOW : WANT_LEN;
                end
                WANT_TAG_LOW:
                begin
                    tag_acc = {tag_acc[7:0], b};
                    walk    = WANT_LEN;
                end
                WANT_LEN:
                begin
                    if (b[7])
                    begin
                        if (b[6:0] > MAX_LENGTH_BYTES)
                        begin
                            due_q.push_back(make_word(tag_acc, elem_start, '0,
                                                      {25'd0, b[6:0]}, 1'b0, ST_LEN_LONG));
                            search_done = 1'b1;
                            walk        = WANT_TAG;
                        end
                        else if (b[6:0] == 7'd0)
                        begin
                            len_acc  = '0;
                            hdr_done = 1'b1;
                        end
                        else
                        begin
                            len_acc        = '0;
                            len_bytes_left = b[2:0];
                            walk           = WANT_LEN_BYTES;
                        end
                    end
                    else
                    begin
                        len_acc  = {24'd0, b};
                        hdr_done = 1'b1;
                    end
                end
                WANT_LEN_BYTES:
                begin
                    len_acc = {len_acc[23:0], b};
                    if (len_bytes_left != 3'd0)
                        len_bytes_left = len_bytes_left - 3'd1;
                    if (len_bytes_left == 3'd0)
                        hdr_done = 1'b1;
                end
                default:
                begin
                    if (value_left != 32'd0)
                        value_left = value_left - 32'd1;
                    if (value_left == 32'd0)
                        complete = 1'b1;
                end
            endcase

            if (hdr_done)
            begin
                value_start = here + 32'd1;
                if (len_acc == 32'd0)
                    complete = 1'b1;
                else
                begin
                    value_left = len_acc;
                    walk       = IN_VALUE;
                end
            end

            if (complete)
            begin
                hit  = tag_hit(tag_acc);
                walk = WANT_TAG;
                if (every_element)
                    due_q.push_back(make_word(tag_acc, elem_start, value_start, len_acc,
                                              hit, ST_ELEMENT));
                else if (hit)
                begin
                    due_q.push_back(make_word(tag_acc, elem_start, value_start, len_acc,
                                              1'b1, ST_ELEMENT));
                    search_done = 1'b1;
                end
            end
        end

        if (eob)
        begin
            if (!search_done)
            begin
                if (walk != WANT_TAG)
                    due_q.push_back(make_word(tag_acc, elem_start, value_start, len_acc,
                                              1'b0, ST_TRUNCATED));
                if (!every_element)
                    due_q.push_back(make_word('0, '0, '0, '0, 1'b0, ST_NOT_FOUND));
            end
            clear_walk();
        end

        if (due_q.size() > first_new)
            due_q[due_q.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MATCH_TAGS; i++)
                tag_list[i] = '0;
            tags_active   = 3'd1;
            every_element = 1'b0;
            clear_walk();
            due_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: result word mismatch, expected none, got tag %0h status %0d",
                             $time, m_axis_tdata[15:0], m_axis_tuser);
                end
                else
                begin
                    want = due_q.pop_front();
                    compare_field("element_tag", 32'(want.element_tag), 32'(m_axis_tdata[15:0]));
                    compare_field("element_offset", want.element_offset, m_axis_tdata[47:16]);
                    compare_field("value_offset", want.value_offset, m_axis_tdata[79:48]);
                    compare_field("value_length", want.value_length, m_axis_tdata[111:80]);
                    compare_field("tag_matched", 32'(want.tag_matched), 32'(m_axis_tdata[112]));
                    compare_field("status", 32'(want.status), 32'(m_axis_tuser));
                    compare_field("last_of_run", 32'(want.last_of_run), 32'(m_axis_tlast));
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MATCH_TAG_0, CFG_MATCH_TAG_1, CFG_MATCH_TAG_2, CFG_MATCH_TAG_3:
                        tag_list[cfg_index[1:0]] = cfg_data;
                    CFG_MATCH_TAG_COUNT:
                        tags_active = cfg_data[2:0];
                    CFG_REPORT_ALL:
                        every_element = cfg_data[0];
                    default:
                        ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                walk_byte(s_axis_tdata, s_axis_tlast);
        end
        mismatches <= err_cnt;
        words_due  <= due_q.size();
    end

endmodule

@@ tb/tb_ber_tlv_header_parser_tag_finder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ber_tlv_header_parser_tag_finder
// Feeds encoded buffers to the BER-TLV tag finder: a directed set covering
// tag and length forms, over-long length fields, truncation, not-found and a
// mode change after a finished search, then random buffers of mostly
// well-formed elements under several register settings. Both streams stall
// at random but for one steady phase. Result words are checked by tlv_report_predictor.
// ----------------------------------------------------------------------------
module tb_ber_tlv_header_parser_tag_finder;
    import btlv_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 285;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    int           mismatches;
    int           words_due;
    int           cycle_count = 0;
    int           bytes_sent = 0;
    bit           steady = 1'b0;
    logic [15:0]  tag_pool [NUM_MATCH_TAGS];
    logic [7:0]   frame[$];

    always #4 clk = ~clk;

    ber_tlv_header_parser_tag_finder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    tlv_report_predictor report_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .words_due     (words_due)
    );

    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 37);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL ber_tlv_header_parser_tag_finder");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        while (!steady && $urandom_range(99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eob;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_frame(input bit close);
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], close && (i == frame.size() - 1));
        bytes_sent += frame.size();
    endtask

    // Wait until every predicted word has come out and the block is quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] t0, input logic [15:0] t1,
                               input logic [15:0] t2, input logic [15:0] t3,
                               input logic [2:0] cnt, input logic rep);
        write_reg(CFG_MATCH_TAG_0, t0);
        write_reg(CFG_MATCH_TAG_1, t1);
        write_reg(CFG_MATCH_TAG_2, t2);
        write_reg(CFG_MATCH_TAG_3, t3);
        write_reg(CFG_MATCH_TAG_COUNT, {13'd0, cnt});
        write_reg(CFG_REPORT_ALL, {15'd0, rep});
        cfg_we <= 1'b0;
        tag_pool[0] = t0;
        tag_pool[1] = t1;
        tag_pool[2] = t2;
        tag_pool[3] = t3;
    endtask

    // Tag with a valid encoding: one byte, or two with the multi-byte mark.
    function automatic logic [15:0] pick_tag();
        logic [7:0] hi;
        logic [7:0] lo;
        hi = 8'($urandom);
        lo = 8'($urandom);
        if ($urandom_range(1) == 0)
        begin
            if (lo[4:0] == TAG_MULTI_MASK)
                lo[0] = 1'b0;
            return {8'h00, lo};
        end
        return {hi | 8'h1F, lo};
    endfunction

    task automatic build_frame();
        logic [15:0] t;
        int          n_elem;
        int          sel;
        int          len;
        int          n;
        int          cut;
        bit          closing;
        frame.delete();
        closing = 1'b0;
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(1, 10)) frame.push_back(8'($urandom));
            return;
        end
        n_elem = $urandom_range(1, 5);
        for (int e = 0; e < n_elem && !closing; e++)
        begin
            t = ($urandom_range(99) < 45) ? tag_pool[$urandom_range(3)] : pick_tag();
            if (t[15:8] != 8'h00)
                frame.push_back(t[15:8]);
            frame.push_back(t[7:0]);

            len = 0;
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                len = $urandom_range(0, 6);
                frame.push_back(8'(len));
            end
            else if (sel < 65)
            begin
                len = (sel == 60) ? 127 : $urandom_range(7, 20);
                frame.push_back(8'(len));
            end
            else if (sel < 86)
            begin
                n   = $urandom_range(0, MAX_LENGTH_BYTES);
                len = (n == 0) ? 0 : $urandom_range(0, 12);
                frame.push_back(8'h80 | 8'(n));
                for (int k = n - 1; k >= 0; k--)
                    frame.push_back(8'(len >> (8 * k)));
            end
            else if (sel < 93)
            begin
                frame.push_back(8'h80 | 8'($urandom_range(MAX_LENGTH_BYTES + 1, 127)));
                closing = 1'b1;
            end
            else
            begin
                // length of 16M or more: never completes inside the buffer
                frame.push_back(8'h84);
                frame.push_back(8'($urandom_range(1, 255)));
                repeat (3) frame.push_back(8'($urandom));
                closing = 1'b1;
            end

            if (closing)
                repeat ($urandom_range(0, 4)) frame.push_back(8'($urandom));
            else
                repeat (len) frame.push_back(8'($urandom));
        end
        if ($urandom_range(99) < 12 && frame.size() > 1)
        begin
            cut = $urandom_range(1, frame.size() - 1);
            repeat (cut) void'(frame.pop_back());
        end
    endtask

    initial
    begin
        logic [15:0] r0;
        logic [15:0] r1;
        logic [15:0] r2;
        logic [15:0] r3;
        int          target;

        for (int i = 0; i < NUM_MATCH_TAGS; i++)
            tag_pool[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: tag 0 active, find-first
        frame = '{8'h00, 8'h00};
        send_frame(1'b1);
        settle();

        load_config(16'h005A, 16'hFFFF, 16'h1F00, 16'h0000, 3'd4, 1'b1);
        frame = '{8'hFF, 8'hFF, 8'h80, 8'h1F, 8'h00, 8'h82, 8'h00, 8'h01, 8'hAB};
        send_frame(1'b1);
        frame = '{8'h00, 8'h85, 8'h11};
        send_frame(1'b1);
        frame = '{8'h7E, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(1'b1);
        settle();

        // find-first: a hit ends the search, a later mode change is ignored
        load_config(16'h005A, 16'hFFFF, 16'h1F00, 16'h0000, 3'd4, 1'b0);
        frame = '{8'h01, 8'h00, 8'h5A, 8'h01, 8'h33};
        send_frame(1'b0);
        settle();
        write_reg(CFG_REPORT_ALL, 16'd1);
        cfg_we <= 1'b0;
        frame = '{8'h02, 8'h00};
        send_frame(1'b1);
        settle();
        write_reg(CFG_REPORT_ALL, 16'd0);
        cfg_we <= 1'b0;
        frame = '{8'h02, 8'h03, 8'hAA};
        send_frame(1'b1);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            r0 = pick_tag();
            r1 = pick_tag();
            r2 = pick_tag();
            r3 = pick_tag();
            case (p)
                0: load_config(16'h0000, 16'hFFFF, r2, r3, 3'd4, 1'b1);
                1: load_config(r0, r1, r2, r3, 3'd0, 1'b0);
                2: load_config(r0, r1, r2, r3, 3'd7, 1'b0);
                3: load_config(r0, r1, r2, r3, 3'($urandom_range(1, 3)), 1'b1);
                4: load_config(16'hFFFF, r1, 16'h0000, r3, 3'd2, 1'b0);
                default: load_config(r0, r1, r2, r3, 3'($urandom_range(0, 7)),
                                     1'($urandom_range(1)));
            endcase
            steady = (p == 3);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
            begin
                build_frame();
                send_frame(1'b1);
            end
        end
        steady = 1'b0;
        settle();

        if (mismatches == 0 && words_due == 0)
            $display("PASS ber_tlv_header_parser_tag_finder");
        else
            $display("FAIL ber_tlv_header_parser_tag_finder");
        $finish;
    end

endmodule
